>>> src/rsc_pkg.sv
// Shared types and constants for the return series covariance block.
// Used by rsc_div and return_series_covariance; depends on nothing.
package rsc_pkg;

    // request kinds on the input stream
    localparam logic [1:0] KIND_BAR     = 2'd0;
    localparam logic [1:0] KIND_COMPUTE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_HIST_LIMIT  = 2'd0;
    localparam logic [1:0] REG_MIN_RETURNS = 2'd1;
    localparam logic [1:0] REG_FALLBACK    = 2'd2;

    localparam int KIND_W     = 2;
    localparam int ASSET_W    = 3;
    localparam int PRICE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 47;
    localparam int HIST_W     = 9;
    localparam int RET_W      = 32;
    localparam int MEAN_W     = 48;
    localparam int COV_W      = 48;
    localparam int ROW_W      = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 56;
    localparam int RET_FRAC   = 24;
    localparam int PROD_SHIFT = 16;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 32;

    localparam int DEF_ASSET_SLOTS = 8;
    localparam int DEF_MAX_HISTORY = 256;

    localparam logic [HIST_W-1:0]     DEF_HIST_LIMIT  = 9'd256;
    localparam logic [HIST_W-1:0]     DEF_MIN_RETURNS = 9'd20;
    localparam logic [CFG_DATA_W-1:0] DEF_FALLBACK    = 47'd429497;

    localparam logic [63:0] RET_MAX = 64'd2147483647;
    localparam logic [63:0] COV_MAX = 64'd140737488355327;
    localparam logic [63:0] COV_NEG = 64'd140737488355328;

endpackage

>>> src/rsc_div.sv
// Radix-2 restoring divider, one quotient bit per clock.
// Depends on rsc_pkg for default widths.
module rsc_div
    import rsc_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // shift in the next numerator bit and try a subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= den;
                quo_reg  <= num;
            end else if (busy_reg) begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> src/return_series_covariance.sv
// Return series covariance: per-asset price windows and sample covariance matrix.
// Depends on rsc_pkg and rsc_div.
//
// A compute request walks every price pair of each requested asset through a shared
// divider (one division a return), then sums each asset's last T returns and divides
// once, then for each of the N*N elements reads each aligned return pair through one read
// port of the return memory, forms the deviations and multiplies them on one multiplier,
// accumulates, and divides once. Short data gives the fallback diagonal at one element a
// clock while the output is not stalled. Results leave row-major, tlast on the final
// element; the block takes no new request until a compute is done.
module return_series_covariance
    import rsc_pkg::*;
#(
    parameter int ASSET_SLOTS = DEF_ASSET_SLOTS,
    parameter int MAX_HISTORY = DEF_MAX_HISTORY
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // asset[2:0], price[34:3], asset_count[38:35]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // row[2:0], col[5:3], covariance[53:6]
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);
    localparam int AS_W   = (ASSET_SLOTS > 1) ? $clog2(ASSET_SLOTS) : 1;
    localparam int PTR_W  = $clog2(MAX_HISTORY);
    localparam int FILL_W = $clog2(MAX_HISTORY + 1);
    localparam int ADDR_W = $clog2(ASSET_SLOTS * MAX_HISTORY);
    localparam int SUM_W  = RET_W + $clog2(MAX_HISTORY) + 1;
    localparam int ACC_W  = 49 + $clog2(MAX_HISTORY) + 1;
    localparam int DEV_W  = MEAN_W + 2;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_R_START = 5'd1;
    localparam logic [4:0] ST_R_PREV  = 5'd2;
    localparam logic [4:0] ST_R_CURR  = 5'd3;
    localparam logic [4:0] ST_R_DIV   = 5'd4;
    localparam logic [4:0] ST_R_NEXT  = 5'd5;
    localparam logic [4:0] ST_CHECK   = 5'd6;
    localparam logic [4:0] ST_FB_EMIT = 5'd7;
    localparam logic [4:0] ST_M_START = 5'd8;
    localparam logic [4:0] ST_M_ISS   = 5'd9;
    localparam logic [4:0] ST_M_ACC   = 5'd10;
    localparam logic [4:0] ST_M_DIV   = 5'd11;
    localparam logic [4:0] ST_C_LDI   = 5'd12;
    localparam logic [4:0] ST_C_LDJ   = 5'd13;
    localparam logic [4:0] ST_C_ISSI  = 5'd14;
    localparam logic [4:0] ST_C_ISSJ  = 5'd15;
    localparam logic [4:0] ST_C_DEV   = 5'd16;
    localparam logic [4:0] ST_C_MUL   = 5'd17;
    localparam logic [4:0] ST_C_ACC   = 5'd18;
    localparam logic [4:0] ST_C_DIV   = 5'd19;
    localparam logic [4:0] ST_C_EMIT  = 5'd20;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [AS_W-1:0] a,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(ADDR_W'(a) * ADDR_W'(MAX_HISTORY)) + ADDR_W'(p);
    endfunction

    // configuration
    logic [HIST_W-1:0]     hist_reg;
    logic [HIST_W-1:0]     minc_reg;
    logic [CFG_DATA_W-1:0] fbvar_reg;

    // per-asset window state
    logic [FILL_W-1:0] fill_reg [ASSET_SLOTS];
    logic [PTR_W-1:0]  head_reg [ASSET_SLOTS];
    logic [FILL_W-1:0] cnt_reg  [ASSET_SLOTS];
    logic signed [MEAN_W-1:0] mean_reg [ASSET_SLOTS];

    // memories
    logic [PRICE_W-1:0] price_mem [ASSET_SLOTS * MAX_HISTORY];
    logic [RET_W-1:0]   ret_mem   [ASSET_SLOTS * MAX_HISTORY];
    logic [PRICE_W-1:0] price_q;
    logic [RET_W-1:0]   ret_q;
    logic               price_rd_en, price_we;
    logic [ADDR_W-1:0]  price_rd_addr, price_wr_addr;
    logic               ret_rd_en, ret_we;
    logic [ADDR_W-1:0]  ret_rd_addr, ret_wr_addr;
    logic [RET_W-1:0]   ret_wr_data;

    // sequencer
    logic [4:0]        state_reg;
    logic [AS_W-1:0]   n_last_reg, i_reg, j_reg;
    logic [PTR_W-1:0]  ptr_reg, ptr_inc;
    logic [FILL_W-1:0] tleft_reg, rcnt_reg, tmin_reg, tcnt_reg;
    logic [PRICE_W-1:0] prev_reg, curr_reg;
    logic              neg_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [PTR_W-1:0]  rptr_i_reg, rptr_j_reg;
    logic [FILL_W-1:0] cnt_i_reg, cnt_j_reg;
    logic signed [MEAN_W-1:0] mean_i_reg, mean_j_reg;
    logic signed [RET_W-1:0]  xi_reg;
    logic [31:0]       mag_i_reg, mag_j_reg;
    logic [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [COV_W-1:0]  cov_reg;

    // output register
    logic                 m_valid_reg, m_last_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // divider
    logic                 div_start_reg;
    logic [DIV_NUM_W-1:0] div_num_reg;
    logic [DIV_DEN_W-1:0] div_den_reg;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    rsc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // request fields
    logic [ASSET_W-1:0] in_asset;
    logic [PRICE_W-1:0] in_price;
    logic [COUNT_W-1:0] in_count;
    logic               s_fire, asset_ok;
    logic [AS_W-1:0]    in_a;
    assign in_asset = s_tdata[2:0];
    assign in_price = s_tdata[34:3];
    assign in_count = s_tdata[38:35];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign asset_ok = 4'(in_asset) < 4'(ASSET_SLOTS);
    assign in_a     = AS_W'(in_asset);

    // clamped history limit
    logic [15:0]       hist16;
    logic [FILL_W-1:0] lim;
    assign hist16 = 16'(hist_reg);
    always_comb begin
        if (hist16 < 16'd2)                 lim = FILL_W'(2);
        else if (hist16 > 16'(MAX_HISTORY)) lim = FILL_W'(MAX_HISTORY);
        else                                lim = FILL_W'(hist16);
    end

    // push: ring slot, fill and head after a bar
    logic [PTR_W+1:0]  pos_sum, trim_sum;
    logic [PTR_W-1:0]  push_pos, head1, head_new, push_head;
    logic [FILL_W-1:0] push_fill, fill1, fill_new;
    logic              fill_lt;
    always_comb begin
        push_fill = fill_reg[in_a];
        push_head = head_reg[in_a];
        pos_sum   = (PTR_W+2)'(push_head) + (PTR_W+2)'(push_fill);
        push_pos  = (pos_sum >= (PTR_W+2)'(MAX_HISTORY)) ?
                    PTR_W'(pos_sum - (PTR_W+2)'(MAX_HISTORY)) : PTR_W'(pos_sum);
        fill_lt   = push_fill < FILL_W'(MAX_HISTORY);
        head1     = fill_lt ? push_head :
                    ((push_head == PTR_W'(MAX_HISTORY - 1)) ? '0 : push_head + 1'b1);
        fill1     = fill_lt ? push_fill + 1'b1 : push_fill;
        trim_sum  = (PTR_W+2)'(head1) + (PTR_W+2)'(fill1 - lim);
        if (fill1 > lim) begin
            head_new = (trim_sum >= (PTR_W+2)'(MAX_HISTORY)) ?
                       PTR_W'(trim_sum - (PTR_W+2)'(MAX_HISTORY)) : PTR_W'(trim_sum);
            fill_new = lim;
        end else begin
            head_new = head1;
            fill_new = fill1;
        end
    end

    assign ptr_inc = (ptr_reg == PTR_W'(MAX_HISTORY - 1)) ? '0 : ptr_reg + 1'b1;

    // return from a price pair
    logic [PRICE_W-1:0] diff_mag;
    logic               diff_neg;
    logic [RET_W-1:0]   ret_val;
    assign diff_neg = price_q < prev_reg;
    assign diff_mag = diff_neg ? prev_reg - price_q : price_q - prev_reg;
    always_comb begin
        if (neg_reg)              ret_val = RET_W'(-div_quo);
        else if (div_quo > RET_MAX) ret_val = RET_W'(RET_MAX);
        else                      ret_val = RET_W'(div_quo);
    end

    // mean sum
    logic signed [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0]        sum_mag;
    assign sum_add = sum_reg + SUM_W'($signed(ret_q));
    assign sum_mag = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);

    // deviations
    logic signed [RET_W-1:0] xj;
    logic signed [DEV_W-1:0] di, dj;
    assign xj = (cnt_j_reg != '0) ? $signed(ret_q) : '0;
    assign di = DEV_W'(xi_reg) - DEV_W'(mean_i_reg);
    assign dj = DEV_W'(xj) - DEV_W'(mean_j_reg);

    // product accumulation
    logic [63:0]             prod_rnd;
    logic signed [ACC_W-1:0] acc_add;
    logic [ACC_W-1:0]        acc_mag;
    logic [FILL_W-1:0]       cov_den;
    assign prod_rnd = (prod_reg + 64'd32768) >> PROD_SHIFT;
    assign acc_add  = neg_reg ? acc_reg - $signed(ACC_W'(prod_rnd))
                              : acc_reg + $signed(ACC_W'(prod_rnd));
    assign acc_mag  = acc_add[ACC_W-1] ? ACC_W'(-acc_add) : ACC_W'(acc_add);
    assign cov_den  = (tmin_reg > FILL_W'(1)) ? tmin_reg - 1'b1 : FILL_W'(1);

    // saturated covariance
    logic signed [COV_W-1:0] cov_val;
    always_comb begin
        if (neg_reg) cov_val = (div_quo > COV_NEG) ? COV_W'(COV_NEG) : COV_W'(-div_quo);
        else         cov_val = (div_quo > COV_MAX) ? COV_W'(COV_MAX) : COV_W'(div_quo);
    end

    logic [FILL_W-1:0] ld_cnt;
    logic [AS_W-1:0]   ld_sel;
    assign ld_sel = (state_reg == ST_C_LDJ) ? j_reg : i_reg;
    assign ld_cnt = cnt_reg[ld_sel];

    logic [15:0] minc16, tmin16;
    assign minc16 = (minc_reg == '0) ? 16'd1 : 16'(minc_reg);
    assign tmin16 = 16'(tmin_reg);

    // result emission
    logic out_free, emit, last_el;
    logic signed [COV_W-1:0] emit_cov;
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = out_free && (state_reg == ST_FB_EMIT || state_reg == ST_C_EMIT);
    assign last_el  = (i_reg == n_last_reg) && (j_reg == n_last_reg);
    assign emit_cov = (state_reg == ST_C_EMIT) ? cov_reg :
                      ((i_reg == j_reg) ? COV_W'(fbvar_reg) : '0);

    // memory ports
    always_comb begin
        price_rd_en   = 1'b0;
        price_rd_addr = mem_addr(i_reg, ptr_inc);
        ret_rd_en     = 1'b0;
        ret_rd_addr   = mem_addr(i_reg, rptr_i_reg);
        unique case (state_reg)
            ST_R_START: begin
                price_rd_en   = 1'b1;
                price_rd_addr = mem_addr(i_reg, head_reg[i_reg]);
            end
            ST_R_PREV: price_rd_en = 1'b1;
            ST_R_CURR: price_rd_en = (prev_reg == '0) && (tleft_reg != FILL_W'(1));
            ST_R_DIV:  price_rd_en = div_done && (tleft_reg != '0);
            ST_M_ISS, ST_C_ISSI: ret_rd_en = 1'b1;
            ST_C_ISSJ: begin
                ret_rd_en   = 1'b1;
                ret_rd_addr = mem_addr(j_reg, rptr_j_reg);
            end
            default: ;
        endcase
    end

    assign price_we      = s_fire && (s_tuser == KIND_BAR) && asset_ok;
    assign price_wr_addr = mem_addr(in_a, push_pos);
    assign ret_we        = (state_reg == ST_R_DIV) && div_done;
    assign ret_wr_addr   = mem_addr(i_reg, PTR_W'(rcnt_reg));
    assign ret_wr_data   = ret_val;

    always_ff @(posedge aclk) begin
        if (price_we)    price_mem[price_wr_addr] <= in_price;
        if (price_rd_en) price_q <= price_mem[price_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ret_we)    ret_mem[ret_wr_addr] <= ret_wr_data;
        if (ret_rd_en) ret_q <= ret_mem[ret_rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= DEF_HIST_LIMIT;
            minc_reg  <= DEF_MIN_RETURNS;
            fbvar_reg <= DEF_FALLBACK;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                REG_HIST_LIMIT:  hist_reg  <= cfg_wr_data[HIST_W-1:0];
                REG_MIN_RETURNS: minc_reg  <= cfg_wr_data[HIST_W-1:0];
                REG_FALLBACK:    fbvar_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
            m_last_reg  <= last_el;
            m_data_reg  <= {2'b00, emit_cov, ROW_W'(j_reg), ROW_W'(i_reg)};
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            for (int k = 0; k < ASSET_SLOTS; k++) begin
                fill_reg[k] <= '0;
                head_reg[k] <= '0;
            end
        end else begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (s_tuser)
                            KIND_BAR: begin
                                if (asset_ok) begin
                                    fill_reg[in_a] <= fill_new;
                                    head_reg[in_a] <= head_new;
                                end
                            end
                            KIND_CLEAR: begin
                                for (int k = 0; k < ASSET_SLOTS; k++) begin
                                    fill_reg[k] <= '0;
                                    head_reg[k] <= '0;
                                end
                            end
                            KIND_COMPUTE: begin
                                if (in_count != '0) begin
                                    n_last_reg <= (in_count > COUNT_W'(ASSET_SLOTS)) ?
                                                  AS_W'(ASSET_SLOTS - 1) :
                                                  AS_W'(in_count - 1'b1);
                                    i_reg      <= '0;
                                    tmin_reg   <= '0;
                                    state_reg  <= ST_R_START;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // returns of asset i
                ST_R_START: begin
                    rcnt_reg <= '0;
                    if (fill_reg[i_reg] < FILL_W'(2)) begin
                        state_reg <= ST_R_NEXT;
                    end else begin
                        ptr_reg   <= head_reg[i_reg];
                        tleft_reg <= fill_reg[i_reg] - 1'b1;
                        state_reg <= ST_R_PREV;
                    end
                end
                ST_R_PREV: begin
                    prev_reg  <= price_q;
                    ptr_reg   <= ptr_inc;
                    state_reg <= ST_R_CURR;
                end
                ST_R_CURR: begin
                    curr_reg  <= price_q;
                    tleft_reg <= tleft_reg - 1'b1;
                    if (prev_reg == '0) begin
                        prev_reg <= price_q;
                        if (tleft_reg == FILL_W'(1)) begin
                            state_reg <= ST_R_NEXT;
                        end else begin
                            ptr_reg <= ptr_inc;
                        end
                    end else begin
                        neg_reg       <= diff_neg;
                        div_num_reg   <= (DIV_NUM_W'(diff_mag) << RET_FRAC) +
                                         DIV_NUM_W'(prev_reg >> 1);
                        div_den_reg   <= DIV_DEN_W'(prev_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_R_DIV;
                    end
                end
                ST_R_DIV: begin
                    if (div_done) begin
                        rcnt_reg <= rcnt_reg + 1'b1;
                        prev_reg <= curr_reg;
                        if (tleft_reg == '0) begin
                            state_reg <= ST_R_NEXT;
                        end else begin
                            ptr_reg   <= ptr_inc;
                            state_reg <= ST_R_CURR;
                        end
                    end
                end
                ST_R_NEXT: begin
                    cnt_reg[i_reg] <= rcnt_reg;
                    if (rcnt_reg != '0 && (tmin_reg == '0 || rcnt_reg < tmin_reg))
                        tmin_reg <= rcnt_reg;
                    if (i_reg == n_last_reg) begin
                        i_reg     <= '0;
                        state_reg <= ST_CHECK;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_R_START;
                    end
                end
                ST_CHECK: begin
                    i_reg <= '0;
                    j_reg <= '0;
                    state_reg <= (tmin16 < minc16) ? ST_FB_EMIT : ST_M_START;
                end
                // fallback diagonal
                ST_FB_EMIT: begin
                    if (out_free) begin
                        if (last_el) begin
                            state_reg <= ST_IDLE;
                        end else if (j_reg == n_last_reg) begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                // mean of the last T returns
                ST_M_START: begin
                    if (cnt_reg[i_reg] == '0) begin
                        mean_reg[i_reg] <= '0;
                        if (i_reg == n_last_reg) begin
                            i_reg     <= '0;
                            state_reg <= ST_C_LDI;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        rptr_i_reg <= PTR_W'(cnt_reg[i_reg] - tmin_reg);
                        tcnt_reg   <= tmin_reg;
                        sum_reg    <= '0;
                        state_reg  <= ST_M_ISS;
                    end
                end
                ST_M_ISS: begin
                    rptr_i_reg <= rptr_i_reg + 1'b1;
                    state_reg  <= ST_M_ACC;
                end
                ST_M_ACC: begin
                    sum_reg  <= sum_add;
                    tcnt_reg <= tcnt_reg - 1'b1;
                    if (tcnt_reg == FILL_W'(1)) begin
                        neg_reg       <= sum_add[SUM_W-1];
                        div_num_reg   <= DIV_NUM_W'(sum_mag) + DIV_NUM_W'(tmin_reg >> 1);
                        div_den_reg   <= DIV_DEN_W'(tmin_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_M_DIV;
                    end else begin
                        state_reg <= ST_M_ISS;
                    end
                end
                ST_M_DIV: begin
                    if (div_done) begin
                        mean_reg[i_reg] <= neg_reg ? MEAN_W'(-div_quo) : MEAN_W'(div_quo);
                        if (i_reg == n_last_reg) begin
                            i_reg     <= '0;
                            state_reg <= ST_C_LDI;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_M_START;
                        end
                    end
                end
                // one covariance element
                ST_C_LDI: begin
                    cnt_i_reg  <= ld_cnt;
                    mean_i_reg <= mean_reg[ld_sel];
                    rptr_i_reg <= PTR_W'(ld_cnt - tmin_reg);
                    state_reg  <= ST_C_LDJ;
                end
                ST_C_LDJ: begin
                    cnt_j_reg  <= ld_cnt;
                    mean_j_reg <= mean_reg[ld_sel];
                    rptr_j_reg <= PTR_W'(ld_cnt - tmin_reg);
                    acc_reg    <= '0;
                    tcnt_reg   <= tmin_reg;
                    state_reg  <= ST_C_ISSI;
                end
                ST_C_ISSI: begin
                    rptr_i_reg <= rptr_i_reg + 1'b1;
                    state_reg  <= ST_C_ISSJ;
                end
                ST_C_ISSJ: begin
                    xi_reg     <= (cnt_i_reg != '0) ? $signed(ret_q) : '0;
                    rptr_j_reg <= rptr_j_reg + 1'b1;
                    state_reg  <= ST_C_DEV;
                end
                ST_C_DEV: begin
                    mag_i_reg <= di[DEV_W-1] ? 32'(-di) : 32'(di);
                    mag_j_reg <= dj[DEV_W-1] ? 32'(-dj) : 32'(dj);
                    neg_reg   <= di[DEV_W-1] != dj[DEV_W-1];
                    state_reg <= ST_C_MUL;
                end
                ST_C_MUL: begin
                    prod_reg  <= 64'(mag_i_reg) * 64'(mag_j_reg);
                    state_reg <= ST_C_ACC;
                end
                ST_C_ACC: begin
                    acc_reg  <= acc_add;
                    tcnt_reg <= tcnt_reg - 1'b1;
                    if (tcnt_reg == FILL_W'(1)) begin
                        neg_reg       <= acc_add[ACC_W-1];
                        div_num_reg   <= DIV_NUM_W'(acc_mag) + DIV_NUM_W'(cov_den >> 1);
                        div_den_reg   <= DIV_DEN_W'(cov_den);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_C_DIV;
                    end else begin
                        state_reg <= ST_C_ISSI;
                    end
                end
                ST_C_DIV: begin
                    if (div_done) begin
                        cov_reg   <= cov_val;
                        state_reg <= ST_C_EMIT;
                    end
                end
                ST_C_EMIT: begin
                    if (out_free) begin
                        if (last_el) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_C_LDI;
                            if (j_reg == n_last_reg) begin
                                j_reg <= '0;
                                i_reg <= i_reg + 1'b1;
                            end else begin
                                j_reg <= j_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
